// ===== hdl/sst_pkg.sv =====
// Shared types and constants for the station sighting table.
// Used by sst_update and station_sighting_table; no dependencies.
package sst_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned ID_W        = 40;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned INDEX_W     = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  // one slot of the table, all fields but the identity
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  first_ts;
    logic [TIME_W-1:0]  last_ts;
    logic [COUNT_W-1:0] count;
  } sst_rec_t;

  localparam int unsigned REC_W = $bits(sst_rec_t);

  // report fields carried through the search
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  now;
  } sst_rpt_t;

  // result of a known-station update
  typedef struct packed {
    logic              moved;
    logic [CHAN_W-1:0] prev_channel;
  } sst_hit_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } sst_state_t;

endpackage

// ===== hdl/station_sighting_table.sv =====
// Station sighting table: top level with the search sequencer.
// Depends on sst_pkg, sst_ram and sst_update.
// A hit at slot k strobes its result once slots 0 to k have been read and compared;
// a miss or a full-table drop strobes once all fill slots are scanned (fill after any clear).
// Throughput: the id RAM read port scans one slot a cycle, so a word scans at
// most ENTRIES slots; the next word is taken in the cycle its result shows.
// Reset empties the table (fill count to zero); RAM contents are not cleared.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module station_sighting_table #(
  parameter int unsigned ENTRIES = sst_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_clear_first,
  input  logic [sst_pkg::ID_W-1:0]     in_station_id,
  input  logic [sst_pkg::CHAN_W-1:0]   in_radio_channel,
  input  logic [sst_pkg::LEVEL_W-1:0]  in_signal_level,
  input  logic [sst_pkg::TIME_W-1:0]   in_now_seconds,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [sst_pkg::INDEX_W-1:0]  out_entry_index,
  output logic [sst_pkg::COUNT_W-1:0]  out_sightings,
  output logic [sst_pkg::TIME_W-1:0]   out_first_stamp,
  output logic                         out_channel_moved,
  output logic [sst_pkg::CHAN_W-1:0]   out_previous_channel,
  output logic                         out_dropped_full
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned WIDE_W = (IDX_W > sst_pkg::INDEX_W) ? IDX_W : sst_pkg::INDEX_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  sst_pkg::sst_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;

  logic [sst_pkg::ID_W-1:0] key_id_r, key_id_nxt;
  sst_pkg::sst_rpt_t        rpt_r, rpt_nxt;

  logic                          valid_r, valid_nxt;
  logic                          hit_r, hit_nxt;
  logic [IDX_W-1:0]              slot_r, slot_nxt;
  logic [sst_pkg::COUNT_W-1:0]   sight_r, sight_nxt;
  logic [sst_pkg::TIME_W-1:0]    first_r, first_nxt;
  logic                          moved_r, moved_nxt;
  logic [sst_pkg::CHAN_W-1:0]    prev_r, prev_nxt;
  logic                          drop_r, drop_nxt;

  // RAM ports
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     id_we, rec_we;
  logic [IDX_W-1:0]         wr_addr;
  logic [sst_pkg::ID_W-1:0] id_rdata;
  logic [sst_pkg::REC_W-1:0] rec_rdata, rec_wdata;

  sst_pkg::sst_rec_t old_rec, upd_rec, new_rec;
  sst_pkg::sst_hit_t hit_info;
  logic              accept;
  logic              match;
  logic [WIDE_W-1:0] slot_wide;

  assign accept  = start && (state_r == sst_pkg::ST_IDLE);
  assign old_rec = sst_pkg::sst_rec_t'(rec_rdata);
  assign match   = pend_v_r && (id_rdata == key_id_r);
  assign rd_addr = issue_r[IDX_W-1:0];

  sst_ram #(
    .WIDTH (sst_pkg::ID_W),
    .DEPTH (ENTRIES)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (wr_addr),
    .wdata (key_id_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (id_rdata)
  );

  sst_ram #(
    .WIDTH (sst_pkg::REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (wr_addr),
    .wdata (rec_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rec_rdata)
  );

  sst_update u_update (
    .old_rec  (old_rec),
    .rpt      (rpt_r),
    .upd_rec  (upd_rec),
    .new_rec  (new_rec),
    .hit_info (hit_info)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    issue_nxt    = issue_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    key_id_nxt   = key_id_r;
    rpt_nxt      = rpt_r;
    valid_nxt    = 1'b0;
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    sight_nxt    = sight_r;
    first_nxt    = first_r;
    moved_nxt    = moved_r;
    prev_nxt     = prev_r;
    drop_nxt     = drop_r;
    rd_en        = 1'b0;
    id_we        = 1'b0;
    rec_we       = 1'b0;
    wr_addr      = pend_idx_r;
    rec_wdata    = upd_rec;

    unique case (state_r)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          key_id_nxt     = in_station_id;
          rpt_nxt.channel = in_radio_channel;
          rpt_nxt.level   = in_signal_level;
          rpt_nxt.now     = in_now_seconds;
          issue_nxt      = '0;
          pend_v_nxt     = 1'b0;
          if (in_clear_first) begin
            fill_nxt = '0;
          end
          state_nxt = sst_pkg::ST_SCAN;
        end
      end
      sst_pkg::ST_SCAN: begin
        // one read issued and one compare resolved per cycle
        priority if (match) begin
          rec_we     = 1'b1;
          wr_addr    = pend_idx_r;
          rec_wdata  = upd_rec;
          valid_nxt  = 1'b1;
          hit_nxt    = 1'b1;
          slot_nxt   = pend_idx_r;
          sight_nxt  = upd_rec.count;
          first_nxt  = old_rec.first_ts;
          moved_nxt  = hit_info.moved;
          prev_nxt   = hit_info.prev_channel;
          drop_nxt   = 1'b0;
          state_nxt  = sst_pkg::ST_IDLE;
        end else if (issue_r < fill_r) begin
          rd_en        = 1'b1;
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt    = issue_r + CNT_W'(1);
        end else begin
          valid_nxt = 1'b1;
          hit_nxt   = 1'b0;
          moved_nxt = 1'b0;
          prev_nxt  = '0;
          state_nxt = sst_pkg::ST_IDLE;
          if (fill_r == FULL_CNT) begin
            slot_nxt  = '0;
            sight_nxt = '0;
            first_nxt = '0;
            drop_nxt  = 1'b1;
          end else begin
            id_we     = 1'b1;
            rec_we    = 1'b1;
            wr_addr   = fill_r[IDX_W-1:0];
            rec_wdata = new_rec;
            slot_nxt  = fill_r[IDX_W-1:0];
            sight_nxt = sst_pkg::COUNT_ONE;
            first_nxt = rpt_r.now;
            drop_nxt  = 1'b0;
            fill_nxt  = fill_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sst_pkg::ST_IDLE;
      fill_r   <= '0;
      issue_r  <= '0;
      pend_v_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      issue_r  <= issue_nxt;
      pend_v_r <= pend_v_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    key_id_r   <= key_id_nxt;
    rpt_r      <= rpt_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    sight_r    <= sight_nxt;
    first_r    <= first_nxt;
    moved_r    <= moved_nxt;
    prev_r     <= prev_nxt;
    drop_r     <= drop_nxt;
  end

  // slot number reported modulo 64
  assign slot_wide = WIDE_W'(slot_r);

  assign busy                 = (state_r != sst_pkg::ST_IDLE);
  assign out_valid            = valid_r;
  assign out_hit              = hit_r;
  assign out_entry_index      = slot_wide[sst_pkg::INDEX_W-1:0];
  assign out_sightings        = sight_r;
  assign out_first_stamp      = first_r;
  assign out_channel_moved    = moved_r;
  assign out_previous_channel = prev_r;
  assign out_dropped_full     = drop_r;

endmodule

// ===== hdl/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sst_update.sv =====
// Slot update arithmetic: refresh of a known station and a fresh slot.
// Depends on sst_pkg.
module sst_update (
  input  sst_pkg::sst_rec_t old_rec,
  input  sst_pkg::sst_rpt_t rpt,
  output sst_pkg::sst_rec_t upd_rec,
  output sst_pkg::sst_rec_t new_rec,
  output sst_pkg::sst_hit_t hit_info
);

  always_comb begin
    upd_rec            = old_rec;
    upd_rec.channel    = rpt.channel;
    upd_rec.level      = rpt.level;
    upd_rec.last_ts    = rpt.now;
    // saturating sighting count
    if (old_rec.count != sst_pkg::COUNT_MAX) begin
      upd_rec.count = old_rec.count + sst_pkg::COUNT_ONE;
    end

    new_rec.channel    = rpt.channel;
    new_rec.level      = rpt.level;
    new_rec.first_ts   = rpt.now;
    new_rec.last_ts    = rpt.now;
    new_rec.count      = sst_pkg::COUNT_ONE;

    hit_info.moved        = (old_rec.channel != rpt.channel);
    hit_info.prev_channel = old_rec.channel;
  end

endmodule
